// ===== design/pts_pkg.sv =====
// Shared types and constants for the PWM timer set-up calculator.
package pts_pkg;

    // Timer input clock in Hz.
    localparam int unsigned CLOCK_HZ = 16000000;

    localparam int CLK_BITS = $clog2(CLOCK_HZ + 1);
    localparam int FREQ_W   = 24;
    localparam int DUTY_W   = 8;
    localparam int CHAN_W   = 2;
    localparam int STAT_W   = 2;
    localparam int CSEL_W   = 3;
    localparam int TOP_W    = 16;

    // Divider width covers CLOCK_HZ and the 24-bit frequency.
    localparam int DIV_W = (CLK_BITS > FREQ_W) ? CLK_BITS : FREQ_W;
    localparam int CNT_W = $clog2(DIV_W + 1);

    localparam int PROD_W   = TOP_W + 1 + 7;
    localparam int IN_BITS  = FREQ_W + DUTY_W + CHAN_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STAT_W + CSEL_W + 2 * TOP_W + CHAN_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [TOP_W:0] MAX_TICKS  = 17'd65536;
    localparam logic [6:0]     DUTY_FULL  = 7'd100;

    // x / 100 as (x * ceil(2^30 / 100)) >> 30, exact for x < 14e6;
    // the duty product is at most 65536 * 99.
    localparam int RECIP_W   = 24;
    localparam logic [RECIP_W-1:0] PCT_RECIP = 24'd10737419;
    localparam int PCT_SHIFT = 30;
    localparam int SCALE_W   = PROD_W + RECIP_W;

    // Prescalers 1, 8, 64, 256, 1024 as right shifts of CLOCK_HZ / f.
    localparam int PRESC_N = 5;
    localparam int PRESC_SHIFT [PRESC_N] = '{0, 3, 6, 8, 10};

    localparam logic [CSEL_W-1:0] CSEL_STOP = '0;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_FREQ = 2'd1,
        ST_NO_FIT    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICKS,
        S_MUL,
        S_CMP,
        S_FINISH
    } pts_state_t;

    typedef struct packed {
        logic load_in;
        logic start_ticks;
        logic pick;
        logic mul;
        logic take_cmp;
        logic load_out;
    } pts_cmd_t;

    typedef struct packed {
        logic freq_zero;
        logic div_done;
        logic need_cmp;
        logic out_free;
    } pts_sts_t;

endpackage

// ===== design/pwm_timer_setup_calc.sv =====
// Top level of the PWM timer set-up calculator.
// Usage:
//   Slave channel (s_*) takes one request per transaction: requested frequency,
//   duty percent and compare channel. Master channel (m_*) returns one result
//   per request: status, clock-select code, TOP, compare value, channel echo.
//   One request is worked at a time; s_tready is high only while idle.
//   A restoring divider of W bits (W = 24 at a 16 MHz clock) forms
//   CLOCK_HZ / f; the duty scaling (TOP + 1) * duty / 100 is a
//   multiply followed by a reciprocal multiply, the latter only when a
//   prescaler fits and duty is 1..99. A zero frequency skips the divider.
//   The result sits in an output register, so a new request is accepted
//   while the previous result waits; if the receiver still stalls when the
//   next result is ready, the block holds it and s_tready stays low.
//   Reset (aresetn low, synchronous) returns the sequencer to idle and
//   drops m_tvalid; no clearing pass is needed.
module pwm_timer_setup_calc (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // frequency_hz[23:0], duty_percent[31:24], channel[33:32], zero pad
    input  logic [pts_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // status[1:0], clock_select[4:2], top_value[20:5], compare_value[36:21],
    // channel_out[38:37], zero pad
    output logic [pts_pkg::OUT_W-1:0] m_tdata
);
    import pts_pkg::*;

    pts_cmd_t cmd;
    pts_sts_t sts;

    pts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pts_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// ===== design/pts_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pts_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [pts_pkg::DIV_W-1:0] num,
    input  logic [pts_pkg::DIV_W-1:0] den,
    output logic [pts_pkg::DIV_W-1:0] quo,
    output logic                     done
);
    import pts_pkg::*;

    logic [DIV_W:0]   rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
    assign fits   = (rem_sh >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// ===== design/pts_ctrl.sv =====
// Sequencer for the set-up calculation.
module pts_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pts_pkg::pts_sts_t sts,
    output pts_pkg::pts_cmd_t cmd
);
    import pts_pkg::*;

    pts_state_t state_reg, state_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = sts.freq_zero ? S_FINISH : S_TICKS;
                end
            end
            S_TICKS: begin
                if (sts.div_done) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                state_next = sts.need_cmp ? S_CMP : S_FINISH;
            end
            S_CMP: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                cmd.load_in     = accept;
                cmd.start_ticks = accept && !sts.freq_zero;
            end
            S_TICKS: begin
                cmd.pick = sts.div_done;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
            end
            S_CMP: begin
                cmd.take_cmp = 1'b1;
            end
            S_FINISH: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/pts_dpath.sv =====
// Datapath: operand registers, prescaler pick, duty product and result register.
module pts_dpath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [pts_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pts_pkg::OUT_W-1:0]  m_tdata,
    input  pts_pkg::pts_cmd_t          cmd,
    output pts_pkg::pts_sts_t          sts
);
    import pts_pkg::*;

    logic [FREQ_W-1:0] in_freq;
    logic [DUTY_W-1:0] in_duty;
    logic [CHAN_W-1:0] in_chan;

    logic [6:0]        duty_reg;
    logic [CHAN_W-1:0] chan_reg;
    status_t           status_reg;
    logic [CSEL_W-1:0] csel_reg;
    logic [TOP_W-1:0]  top_reg;
    logic [TOP_W-1:0]  cmp_reg;
    logic [PROD_W-1:0] prod_reg;

    status_t           o_status_reg;
    logic [CSEL_W-1:0] o_csel_reg;
    logic [TOP_W-1:0]  o_top_reg;
    logic [TOP_W-1:0]  o_cmp_reg;
    logic [CHAN_W-1:0] o_chan_reg;
    logic              o_valid_reg;

    logic              div_start;
    logic [DIV_W-1:0]  div_num;
    logic [DIV_W-1:0]  div_den;
    logic [DIV_W-1:0]  div_quo;
    logic              div_done;

    logic              pick_found;
    logic [CSEL_W-1:0] pick_csel;
    logic [TOP_W-1:0]  pick_top;
    logic [PROD_W-1:0] prod_full;
    logic [SCALE_W-1:0] scale_full;

    assign in_freq = s_tdata[FREQ_W-1:0];
    assign in_duty = s_tdata[FREQ_W +: DUTY_W];
    assign in_chan = s_tdata[FREQ_W+DUTY_W +: CHAN_W];

    assign div_start = cmd.start_ticks;
    assign div_num   = DIV_W'(CLOCK_HZ);
    assign div_den   = DIV_W'(in_freq);

    pts_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .done    (div_done)
    );

    // ticks at prescaler 2^s equals (CLOCK_HZ / f) >> s; take the first that fits
    always_comb begin
        logic [DIV_W-1:0] ticks;
        pick_found = 1'b0;
        pick_csel  = CSEL_STOP;
        pick_top   = '0;
        for (int i = 0; i < PRESC_N; i++) begin
            ticks = div_quo >> PRESC_SHIFT[i];
            if (!pick_found && (ticks != '0) && (ticks <= DIV_W'(MAX_TICKS))) begin
                pick_found = 1'b1;
                pick_csel  = CSEL_W'(i + 1);
                pick_top   = ticks[TOP_W-1:0] - 1'b1;
            end
        end
    end

    assign prod_full = PROD_W'({1'b0, top_reg} + 17'd1) * PROD_W'(duty_reg);

    // divide by 100 through the reciprocal, on the product registered in the cycle before
    assign scale_full = SCALE_W'(prod_reg) * SCALE_W'(PCT_RECIP);

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            duty_reg   <= (in_duty > DUTY_W'(DUTY_FULL)) ? DUTY_FULL : in_duty[6:0];
            chan_reg   <= in_chan;
            status_reg <= (in_freq == '0) ? ST_ZERO_FREQ : ST_OK;
            csel_reg   <= CSEL_STOP;
            top_reg    <= '0;
            cmp_reg    <= '0;
        end
        if (cmd.pick) begin
            if (pick_found) begin
                csel_reg <= pick_csel;
                top_reg  <= pick_top;
                cmp_reg  <= (duty_reg == DUTY_FULL) ? pick_top : '0;
            end else begin
                status_reg <= ST_NO_FIT;
            end
        end
        if (cmd.mul) begin
            prod_reg <= prod_full;
        end
        if (cmd.take_cmp) begin
            cmp_reg <= scale_full[PCT_SHIFT +: TOP_W];
        end
        if (cmd.load_out) begin
            o_status_reg <= status_reg;
            o_csel_reg   <= csel_reg;
            o_top_reg    <= top_reg;
            o_cmp_reg    <= cmp_reg;
            o_chan_reg   <= chan_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            o_valid_reg <= 1'b1;
        end else if (m_tready) begin
            o_valid_reg <= 1'b0;
        end
    end

    assign sts.freq_zero = (in_freq == '0);
    assign sts.div_done  = div_done;
    assign sts.need_cmp  = (status_reg == ST_OK) && (duty_reg != '0) && (duty_reg != DUTY_FULL);
    assign sts.out_free  = !o_valid_reg || m_tready;

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = OUT_W'({o_chan_reg, o_cmp_reg, o_top_reg, o_csel_reg, o_status_reg});

endmodule
